>>> sv/lru_region_slot_directory_top_macros.svh
// ----------------------------------------------------------------------------
// lru_region_slot_directory_top_macros
// Assertion macros shared by the region slot directory RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_REGION_SLOT_DIRECTORY_TOP_MACROS_SVH
`define LRU_REGION_SLOT_DIRECTORY_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LRSD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LRSD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/lrsd_pkg.sv
// ----------------------------------------------------------------------------
// lrsd_pkg
// Shared constants and types for the LRU region slot directory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lrsd_pkg;

    // Default number of directory slots
    localparam int SLOTS_DEF = 4;

    // Field widths
    localparam int REGION_W  = 32;
    localparam int SLOT_W    = 2;
    localparam int OUTCOME_W = 2;

    // Result outcome codes
    typedef enum logic [OUTCOME_W-1:0] {
        OUTCOME_HIT   = 2'd0,
        OUTCOME_FILL  = 2'd1,
        OUTCOME_EVICT = 2'd2
    } outcome_t;

endpackage

>>> sv/lru_region_slot_directory_top.sv
// ----------------------------------------------------------------------------
// lru_region_slot_directory_top
// Fully associative region directory with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one signed region coordinate
//   pair per transaction. Output channel (out_valid/out_ready) returns one
//   result per request: the slot now holding the region, the outcome (hit,
//   fill of a free slot, or eviction) and the evicted region on eviction.
//   Flow: an accepted request is registered in the input register, looked
//   up from there, and its result loads into the result register, which
//   drives out_valid.
//   Throughput: one request per cycle while the output is not stalled. The
//   lookup, victim choice and age update sit in combinational logic between
//   the input register and the result register; the directory state updates
//   at the same edge the result loads, so the next request sees it.
//   Recency is kept as a pairwise age matrix, so picking the victim needs no
//   wide stamp compare.
//   Reset: all slots free, age matrix cleared, both registers empty.
//   Stall: while out_ready is low and a result is held, the pending request
//   waits in the input register and in_ready drops until the output drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "lru_region_slot_directory_top_macros.svh"

module lru_region_slot_directory_top #(
    parameter int SLOTS = lrsd_pkg::SLOTS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic signed [lrsd_pkg::REGION_W-1:0] region_x,
    input  logic signed [lrsd_pkg::REGION_W-1:0] region_y,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic        [lrsd_pkg::SLOT_W-1:0]   slot,
    output logic        [lrsd_pkg::OUTCOME_W-1:0] outcome,
    output logic signed [lrsd_pkg::REGION_W-1:0] old_region_x,
    output logic signed [lrsd_pkg::REGION_W-1:0] old_region_y
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Input register
    logic                                 in_valid_reg;
    logic signed [lrsd_pkg::REGION_W-1:0] rx_reg;
    logic signed [lrsd_pkg::REGION_W-1:0] ry_reg;

    // Directory state
    logic [SLOTS-1:0]                     slot_valid_reg;
    logic [SLOTS-1:0]                     slot_valid_next;
    logic signed [lrsd_pkg::REGION_W-1:0] tag_x_reg [SLOTS];
    logic signed [lrsd_pkg::REGION_W-1:0] tag_y_reg [SLOTS];
    // older_reg[i][j]: slot i was last touched before slot j
    logic [SLOTS-1:0]                     older_reg  [SLOTS];
    logic [SLOTS-1:0]                     older_next [SLOTS];

    // Result register
    logic                                 out_valid_reg;
    logic [lrsd_pkg::SLOT_W-1:0]          slot_reg;
    lrsd_pkg::outcome_t                   outcome_reg;
    logic signed [lrsd_pkg::REGION_W-1:0] old_x_reg;
    logic signed [lrsd_pkg::REGION_W-1:0] old_y_reg;

    // Lookup signals
    logic                                 advance;
    logic                                 commit;
    logic [SLOTS-1:0]                     hit_vec;
    logic [SLOTS-1:0]                     lru_vec;
    logic                                 any_hit;
    logic                                 any_free;
    logic [IDX_W-1:0]                     hit_idx;
    logic [IDX_W-1:0]                     free_idx;
    logic [IDX_W-1:0]                     lru_idx;
    logic [IDX_W-1:0]                     pick;
    logic [IDX_W+1:0]                     pick_ext;
    lrsd_pkg::outcome_t                   outcome_next;
    logic signed [lrsd_pkg::REGION_W-1:0] old_x_next;
    logic signed [lrsd_pkg::REGION_W-1:0] old_y_next;

    // Handshake: the result register frees up when empty or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign commit   = in_valid_reg && advance;
    assign in_ready = !in_valid_reg || advance;

    // Compare tags and find LRU candidates in parallel
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            hit_vec[i] = slot_valid_reg[i] && (tag_x_reg[i] == rx_reg)
                         && (tag_y_reg[i] == ry_reg);
            lru_vec[i] = slot_valid_reg[i];
            for (int j = 0; j < SLOTS; j++)
            begin
                if (j != i)
                begin
                    lru_vec[i] = lru_vec[i] && older_reg[i][j];
                end
            end
        end
    end

    // Priority encode: lowest hit, highest free slot, lowest LRU candidate
    always_comb
    begin
        hit_idx  = '0;
        free_idx = '0;
        lru_idx  = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (hit_vec[i])
            begin
                hit_idx = IDX_W'(i);
            end
            if (lru_vec[i])
            begin
                lru_idx = IDX_W'(i);
            end
        end
        for (int i = 0; i < SLOTS; i++)
        begin
            if (!slot_valid_reg[i])
            begin
                free_idx = IDX_W'(i);
            end
        end
    end

    assign any_hit  = |hit_vec;
    assign any_free = !(&slot_valid_reg);

    // Choose the slot and the outcome
    always_comb
    begin
        old_x_next = '0;
        old_y_next = '0;
        if (any_hit)
        begin
            pick         = hit_idx;
            outcome_next = lrsd_pkg::OUTCOME_HIT;
        end
        else if (any_free)
        begin
            pick         = free_idx;
            outcome_next = lrsd_pkg::OUTCOME_FILL;
        end
        else
        begin
            pick         = lru_idx;
            outcome_next = lrsd_pkg::OUTCOME_EVICT;
            old_x_next   = tag_x_reg[lru_idx];
            old_y_next   = tag_y_reg[lru_idx];
        end
    end

    assign pick_ext = {2'b00, pick};

    // Mark the picked slot valid and most recently used
    always_comb
    begin
        slot_valid_next = slot_valid_reg;
        for (int i = 0; i < SLOTS; i++)
        begin
            older_next[i] = older_reg[i];
        end
        if (commit)
        begin
            slot_valid_next[pick] = 1'b1;
            for (int j = 0; j < SLOTS; j++)
            begin
                older_next[pick][j] = 1'b0;
                if (IDX_W'(j) != pick)
                begin
                    older_next[j][pick] = 1'b1;
                end
            end
        end
    end

    // Hold the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            rx_reg <= region_x;
            ry_reg <= region_y;
        end
    end

    // Advance directory control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                older_reg[i] <= '0;
            end
        end
        else
        begin
            slot_valid_reg <= slot_valid_next;
            for (int i = 0; i < SLOTS; i++)
            begin
                older_reg[i] <= older_next[i];
            end
        end
    end

    // Write the requested region into the picked slot on a miss
    always_ff @(posedge clk)
    begin
        if (commit && !any_hit)
        begin
            tag_x_reg[pick] <= rx_reg;
            tag_y_reg[pick] <= ry_reg;
        end
    end

    // Load the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            slot_reg    <= pick_ext[lrsd_pkg::SLOT_W-1:0];
            outcome_reg <= outcome_next;
            old_x_reg   <= old_x_next;
            old_y_reg   <= old_y_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign slot         = slot_reg;
    assign outcome      = outcome_reg;
    assign old_region_x = old_x_reg;
    assign old_region_y = old_y_reg;

    // Checks
    `LRSD_ASSERT_NOW(a_tags_unique, in_valid_reg, $onehot0(hit_vec),
        "region held by more than one slot")
    `LRSD_ASSERT_NOW(a_single_lru, &slot_valid_reg, $onehot(lru_vec),
        "full directory without a unique LRU slot")
    `LRSD_ASSERT_NEXT(a_pick_valid, commit, slot_valid_reg[$past(pick)],
        "picked slot not valid after update")
    `LRSD_ASSERT_NOW(a_old_zero,
        out_valid_reg && (outcome_reg != lrsd_pkg::OUTCOME_EVICT),
        (old_x_reg == '0) && (old_y_reg == '0),
        "old region nonzero without eviction")

endmodule
